@@ rtl/cfir_pkg.sv @@
// Package for the complex I/Q FIR filter: function codes, sequencer states,
// datapath control bundle and fixed field widths.
// Depends on nothing; used by cfir_mac and complex_fir_filter.
package cfir_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int INDEX_W  = 5;
  localparam int FUNC_W   = 2;

  // Coefficients are consumed four bits at a time, most significant digit first.
  localparam int DIGIT_W  = 4;
  localparam int DIGITS   = COEF_W / DIGIT_W;
  localparam int DIG_CNT_W = $clog2(DIGITS);
  localparam int PROD_W   = SAMPLE_W + DIGIT_W + 1;
  localparam int MUL_W    = SAMPLE_W + COEF_W;

  localparam int S_TDATA_W = ((2 * SAMPLE_W + INDEX_W + COEF_W + 7) / 8) * 8;
  localparam int M_TDATA_W = 2 * SAMPLE_W;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH  = 2'd0,
    FUNC_COEF  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic start;        // clear partial product and accumulator
    logic step;         // one digit step of the serial multiply
    logic first_digit;  // step handles the signed top digit
    logic flush;        // add the last partial product
  } mac_ctrl_t;

endpackage

@@ rtl/cfir_mac.sv @@
// One rail of the filter: digit-serial multiply, accumulate, round and saturate.
// Depends on cfir_pkg for widths and the control bundle.
module cfir_mac #(
  parameter int ACC_W = 37
) (
  input  logic                                 clk,
  input  cfir_pkg::mac_ctrl_t                  ctrl,
  input  logic signed [cfir_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [cfir_pkg::DIGIT_W:0]    digit,
  output logic signed [cfir_pkg::SAMPLE_W-1:0] result,
  output logic                                 clipped
);
  import cfir_pkg::*;

  localparam int RND_W = ACC_W - 15;

  logic signed [PROD_W-1:0] prod;
  logic signed [MUL_W-1:0]  part;
  logic signed [MUL_W-1:0]  part_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  biased;
  logic signed [RND_W-1:0]  shifted;
  logic                     fits;

  assign prod = $signed({{(PROD_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample})
              * $signed({{(PROD_W-DIGIT_W-1){digit[DIGIT_W]}}, digit});

  // Horner step: shift up a digit and add the new product; top digit loads.
  always_comb begin
    if (ctrl.first_digit) begin
      part_next = MUL_W'(prod);
    end else begin
      part_next = (part <<< DIGIT_W) + MUL_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      part <= '0;
      acc  <= '0;
    end else begin
      if (ctrl.step) begin
        part <= part_next;
      end
      if (ctrl.first_digit || ctrl.flush) begin
        acc <= acc + ACC_W'(part);
      end
    end
  end

  // Round half up, then clip to 16 bits.
  assign biased  = acc + ACC_W'(16384);
  assign shifted = RND_W'(biased >>> 15);
  assign fits    = (shifted[RND_W-1:SAMPLE_W-1] == '0) || (shifted[RND_W-1:SAMPLE_W-1] == '1);

  always_comb begin
    clipped = !fits;
    if (fits) begin
      result = shifted[SAMPLE_W-1:0];
    end else if (shifted[RND_W-1]) begin
      result = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

@@ rtl/complex_fir_filter.sv @@
// Top level of the complex I/Q direct-form FIR filter with shared real taps.
// Depends on cfir_pkg and cfir_mac.
//
// Each input item carries a function in s_tuser. A push item shifts one I/Q
// sample into the delay line and, after the filter sum is formed, produces one
// output item with both rails rounded to Q1.15 and saturated, plus a flag in
// m_tuser that is set when either rail clipped. A coefficient item writes one
// Q1.15 tap (indexes at or above TAPS are ignored), a clear item zeroes the
// delay line, and the unused function code does nothing; none of these give an
// output item. For a push item the delay line and the tap store are rotating
// shift registers that present each tap in turn to a multiplier that consumes
// four coefficient bits per cycle; the flush state then finishes the sum and
// the round state loads the rounded result into the output register, waiting
// while that register still holds an item. Other items take effect when they
// are accepted. A new item is taken only once the previous push has reached
// the output register, which holds the result until the downstream side takes
// it, so the next sum runs while a result waits.
module complex_fir_filter #(
  parameter int TAPS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // sample_i [15:0], sample_q [31:16], coef_index [36:32], coef_value [52:37]
  input  logic [cfir_pkg::S_TDATA_W-1:0]     s_tdata,
  // func [1:0]
  input  logic [cfir_pkg::FUNC_W-1:0]        s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_i [15:0], out_q [31:16]
  output logic [cfir_pkg::M_TDATA_W-1:0]     m_tdata,
  // saturated [0]
  output logic                               m_tuser
);
  import cfir_pkg::*;

  localparam int TAP_W = $clog2(TAPS);
  localparam int ACC_W = MUL_W + TAP_W;

  state_t state;
  state_t state_next;

  func_t                      func;
  logic signed [SAMPLE_W-1:0] in_i;
  logic signed [SAMPLE_W-1:0] in_q;
  logic [INDEX_W-1:0]         in_index;
  logic signed [COEF_W-1:0]   in_coef;
  logic                       accept;

  // Delay lines: entry 0 is the newest sample. Tap store: entry j is tap j.
  // During a sum both rotate together, so entry 0 always holds a matching pair.
  logic signed [SAMPLE_W-1:0] hist_i [TAPS];
  logic signed [SAMPLE_W-1:0] hist_q [TAPS];
  logic signed [COEF_W-1:0]   coef   [TAPS];

  logic [TAP_W-1:0]     tap_cnt;
  logic [DIG_CNT_W-1:0] dig;
  logic signed [DIGIT_W:0] digit;

  mac_ctrl_t ctrl;
  logic      rotate;
  logic      load_out;

  logic signed [SAMPLE_W-1:0] res_i;
  logic signed [SAMPLE_W-1:0] res_q;
  logic                       clip_i;
  logic                       clip_q;

  assign func     = func_t'(s_tuser);
  assign in_i     = s_tdata[SAMPLE_W-1:0];
  assign in_q     = s_tdata[2*SAMPLE_W-1:SAMPLE_W];
  assign in_index = s_tdata[2*SAMPLE_W+INDEX_W-1:2*SAMPLE_W];
  assign in_coef  = s_tdata[2*SAMPLE_W+INDEX_W+COEF_W-1:2*SAMPLE_W+INDEX_W];
  assign accept   = s_tvalid && s_tready;

  // The top digit of a coefficient carries its sign; the others are unsigned.
  always_comb begin
    if (dig == DIG_CNT_W'(DIGITS-1)) begin
      digit = {coef[0][COEF_W-1], coef[0][COEF_W-1 -: DIGIT_W]};
    end else begin
      digit = {1'b0, coef[0][{dig, 2'b00} +: DIGIT_W]};
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && func == FUNC_PUSH) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (dig == '0 && tap_cnt == TAP_W'(TAPS-1)) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    s_tready         = 1'b0;
    ctrl.start       = 1'b0;
    ctrl.step        = 1'b0;
    ctrl.first_digit = 1'b0;
    ctrl.flush       = 1'b0;
    rotate           = 1'b0;
    load_out         = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        ctrl.start = s_tvalid && func == FUNC_PUSH;
      end
      ST_MAC: begin
        ctrl.step        = 1'b1;
        ctrl.first_digit = dig == DIG_CNT_W'(DIGITS-1);
        rotate           = dig == '0;
      end
      ST_FLUSH: begin
        ctrl.flush = 1'b1;
      end
      ST_ROUND: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      tap_cnt <= '0;
      dig     <= DIG_CNT_W'(DIGITS-1);
    end else begin
      state <= state_next;
      if (ctrl.start) begin
        tap_cnt <= '0;
        dig     <= DIG_CNT_W'(DIGITS-1);
      end else if (ctrl.step) begin
        dig <= dig - 1'b1;
        if (rotate) begin
          tap_cnt <= tap_cnt + 1'b1;
        end
      end
    end
  end

  // Delay lines and tap store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_i[k] <= '0;
        hist_q[k] <= '0;
        coef[k]   <= '0;
      end
    end else if (accept && func == FUNC_PUSH) begin
      hist_i[0] <= in_i;
      hist_q[0] <= in_q;
      for (int k = 1; k < TAPS; k++) begin
        hist_i[k] <= hist_i[k-1];
        hist_q[k] <= hist_q[k-1];
      end
    end else if (accept && func == FUNC_CLEAR) begin
      for (int k = 0; k < TAPS; k++) begin
        hist_i[k] <= '0;
        hist_q[k] <= '0;
      end
    end else if (accept && func == FUNC_COEF) begin
      for (int k = 0; k < TAPS; k++) begin
        if (int'(in_index) == k) begin
          coef[k] <= in_coef;
        end
      end
    end else if (rotate) begin
      hist_i[TAPS-1] <= hist_i[0];
      hist_q[TAPS-1] <= hist_q[0];
      coef[TAPS-1]   <= coef[0];
      for (int k = 0; k < TAPS-1; k++) begin
        hist_i[k] <= hist_i[k+1];
        hist_q[k] <= hist_q[k+1];
        coef[k]   <= coef[k+1];
      end
    end
  end

  cfir_mac #(
    .ACC_W(ACC_W)
  ) u_mac_i (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (hist_i[0]),
    .digit  (digit),
    .result (res_i),
    .clipped(clip_i)
  );

  cfir_mac #(
    .ACC_W(ACC_W)
  ) u_mac_q (
    .clk    (clk),
    .ctrl   (ctrl),
    .sample (hist_q[0]),
    .digit  (digit),
    .result (res_q),
    .clipped(clip_q)
  );

  // Output register: holds a finished item until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {res_q, res_i};
      m_tuser <= clip_i || clip_q;
    end
  end

endmodule
